/* rtl/core/ccbb_pkg.sv */
`timescale 1ns / 1ps

package ccbb_pkg;

    localparam int MAP_BITS  = 256;
    localparam int MAP_BYTES = MAP_BITS / 8;
    localparam int IDX_W     = $clog2(MAP_BYTES);

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAP_BYTES - 1);

    // characters with a role in the class syntax
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // named escapes and what they stand for
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_E   = 8'h65;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CC_BEL = 8'h07;
    localparam logic [7:0] CC_BS  = 8'h08;
    localparam logic [7:0] CC_ESC = 8'h1B;
    localparam logic [7:0] CC_FF  = 8'h0C;
    localparam logic [7:0] CC_NL  = 8'h0A;
    localparam logic [7:0] CC_CR  = 8'h0D;
    localparam logic [7:0] CC_HT  = 8'h09;
    localparam logic [7:0] CC_VT  = 8'h0B;

    // escape decoder phases
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESCAPE = 2'd1;
    localparam logic [1:0] PH_OCTAL  = 2'd2;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    // previous member code, bit 8 set means none
    localparam logic [8:0] PREV_NONE = 9'h100;

    typedef struct packed {
        logic [MAP_BITS-1:0] member_map;
        logic                at_class_start;
        logic                negated;
        logic [1:0]          escape_phase;
        logic [7:0]          octal_value;
        logic [1:0]          octal_digits;
        logic [8:0]          prev_char;
        logic                range_pending;
        logic                class_ended;
    } ccbb_state_t;

    localparam ccbb_state_t STATE_RESET = '{
        member_map:     '0,
        at_class_start: 1'b1,
        negated:        1'b0,
        escape_phase:   PH_NORMAL,
        octal_value:    8'h00,
        octal_digits:   2'd0,
        prev_char:      PREV_NONE,
        range_pending:  1'b0,
        class_ended:    1'b0
    };

    // finished map handed from the decoder to the output buffer
    typedef struct packed {
        logic                load;
        logic [MAP_BITS-1:0] map;
    } ccbb_load_t;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [7:0] named_escape(logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_A:    r = CC_BEL;
            CH_B:    r = CC_BS;
            CH_E:    r = CC_ESC;
            CH_F:    r = CC_FF;
            CH_N:    r = CC_NL;
            CH_R:    r = CC_CR;
            CH_T:    r = CC_HT;
            CH_V:    r = CC_VT;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic ccbb_state_t put_bit(ccbb_state_t s, logic [7:0] c);
        ccbb_state_t r;
        r = s;
        r.member_map[c] = !s.negated;
        return r;
    endfunction

    function automatic ccbb_state_t put_literal_dash(ccbb_state_t s);
        ccbb_state_t r;
        r = put_bit(s, CH_DASH);
        r.prev_char = {1'b0, CH_DASH};
        r.range_pending = 1'b0;
        return r;
    endfunction

    function automatic ccbb_state_t take_char(ccbb_state_t s, logic [7:0] c);
        ccbb_state_t r;
        logic [7:0]  kk;
        r = s;
        if (s.range_pending) begin
            // parallel compare against every character code
            if (!s.prev_char[8]) begin
                for (int k = 0; k < MAP_BITS; k++) begin
                    kk = 8'(k);
                    if ((kk >= s.prev_char[7:0]) && (kk <= c)) begin
                        r.member_map[k] = !s.negated;
                    end
                end
            end
            r.prev_char = PREV_NONE;
            r.range_pending = 1'b0;
        end else if (c == CH_NUL) begin
            r.class_ended = 1'b1;
        end else if ((c == CH_DASH) && !s.prev_char[8]) begin
            r.range_pending = 1'b1;
        end else begin
            r = put_bit(s, c);
            r.prev_char = {1'b0, c};
        end
        return r;
    endfunction

    function automatic ccbb_state_t plain_byte(ccbb_state_t s, logic [7:0] b);
        ccbb_state_t r;
        r = s;
        if (!s.class_ended) begin
            if (s.range_pending && (b == CH_NUL)) begin
                r = put_literal_dash(r);
            end
            if (b == CH_BSLASH) begin
                r.escape_phase = PH_ESCAPE;
            end else begin
                r = take_char(r, b);
            end
        end
        return r;
    endfunction

    function automatic ccbb_state_t feed(ccbb_state_t s, logic [7:0] b);
        ccbb_state_t r;
        logic [7:0]  oct;
        logic [1:0]  digits;
        r = s;
        oct = {s.octal_value[4:0], 3'b000} + (b - CH_ZERO);
        digits = s.octal_digits + 2'd1;
        if (!s.class_ended) begin
            if (s.at_class_start && (b == CH_CARET)) begin
                r.at_class_start = 1'b0;
                r.negated = 1'b1;
                r.member_map = '1;
            end else begin
                if (s.at_class_start) begin
                    r.at_class_start = 1'b0;
                    r.negated = 1'b0;
                    r.member_map = '0;
                end
                case (s.escape_phase)
                    PH_ESCAPE: begin
                        if (b == CH_NUL) begin
                            r.escape_phase = PH_NORMAL;
                            r = take_char(r, CH_BSLASH);
                            r = plain_byte(r, CH_NUL);
                        end else if (is_digit(b)) begin
                            r.escape_phase = PH_OCTAL;
                            r.octal_value = b - CH_ZERO;
                            r.octal_digits = 2'd1;
                        end else begin
                            r.escape_phase = PH_NORMAL;
                            r = take_char(r, named_escape(b));
                        end
                    end
                    PH_OCTAL: begin
                        if (is_digit(b)) begin
                            r.octal_value = oct;
                            r.octal_digits = digits;
                            if (digits >= OCT_MAX_DIGITS) begin
                                r.escape_phase = PH_NORMAL;
                                r.octal_digits = 2'd0;
                                r = take_char(r, oct);
                            end
                        end else begin
                            r.escape_phase = PH_NORMAL;
                            r.octal_digits = 2'd0;
                            r = take_char(r, s.octal_value);
                            r = plain_byte(r, b);
                        end
                    end
                    default: begin
                        r.escape_phase = PH_NORMAL;
                        r = plain_byte(r, b);
                    end
                endcase
            end
        end
        return r;
    endfunction

    function automatic ccbb_state_t flush_class(ccbb_state_t s);
        ccbb_state_t r;
        r = s;
        if (!s.class_ended) begin
            if (s.escape_phase == PH_ESCAPE) begin
                r = take_char(r, CH_BSLASH);
            end else if (s.escape_phase == PH_OCTAL) begin
                r = take_char(r, s.octal_value);
            end
            r.escape_phase = PH_NORMAL;
            r.octal_digits = 2'd0;
            if (!r.class_ended && r.range_pending) begin
                r = put_literal_dash(r);
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/ccbb_decode.sv */
`timescale 1ns / 1ps

module ccbb_decode
    import ccbb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_spec_byte,
    input  logic       s_spec_last,
    input  logic       emit_busy_i,
    output ccbb_load_t load_o
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    ccbb_state_t st_reg;
    ccbb_state_t st_fed;
    ccbb_state_t st_flushed;
    logic        take;

    // a last byte waits until the output buffer is free
    assign take    = in_valid_reg && (!in_last_reg || !emit_busy_i);
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        st_fed     = feed(st_reg, in_byte_reg);
        st_flushed = flush_class(st_fed);
    end

    assign load_o.load = take && in_last_reg;
    assign load_o.map  = st_flushed.member_map;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (take) begin
                st_reg <= in_last_reg ? STATE_RESET : st_fed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_spec_byte;
            in_last_reg <= s_spec_last;
        end
    end

    a_fresh_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && in_last_reg) |=> (st_reg.at_class_start && !st_reg.class_ended))
        else $error("state not back at class start after last byte");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        load_o.load |-> !emit_busy_i)
        else $error("map handed over while output buffer busy");

endmodule

/* rtl/core/ccbb_emit.sv */
`timescale 1ns / 1ps

module ccbb_emit
    import ccbb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ccbb_load_t       load_i,
    output logic             busy_o,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_map_byte,
    output logic [IDX_W-1:0] m_map_index,
    output logic             m_map_last
);

    logic [MAP_BITS-1:0] map_buf_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                busy_reg;

    assign busy_o      = busy_reg;
    assign m_valid     = busy_reg;
    assign m_map_byte  = map_buf_reg[{idx_reg, 3'b000} +: 8];
    assign m_map_index = idx_reg;
    assign m_map_last  = (idx_reg == LAST_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load_i.load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == LAST_INDEX) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i.load) begin
            map_buf_reg <= load_i.map;
        end
    end

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_map_last) |=> !m_valid)
        else $error("output still valid after final map byte");

    a_start_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_map_index == '0))
        else $error("map burst does not start at byte zero");

    a_index_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(idx_reg))
        else $error("beat index moved while stalled");

endmodule

/* rtl/core/char_class_bitmap_builder_unit.sv */
`timescale 1ns / 1ps
// path: last spec byte waits in the input register, then its map is loaded into the output buffer
// throughput: one spec byte per cycle, set by the single-pass decode between the
// input register and the map state; each class then drains as 32 map beats
// a last byte waits while the previous map still drains, so the next map loads only after its last beat
// reset: synchronous active-low aresetn empties the input register and output buffer
// and returns the map state to class start with an all-zero map

module char_class_bitmap_builder_unit
    import ccbb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // spec byte requests
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_spec_byte,
    input  logic             s_spec_last,
    // map byte requests
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_map_byte,
    output logic [IDX_W-1:0] m_map_index,
    output logic             m_map_last
);

    // finished map plus its strobe, one cycle per class
    ccbb_load_t load;
    // output buffer still holds a map that is draining
    logic       emit_busy;

    // input register, escape and range decode, membership map
    ccbb_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_spec_byte (s_spec_byte),
        .s_spec_last (s_spec_last),
        .emit_busy_i (emit_busy),
        .load_o      (load)
    );

    // 256-bit snapshot of the map, sent out one byte per beat
    ccbb_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_i      (load),
        .busy_o      (emit_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_map_byte  (m_map_byte),
        .m_map_index (m_map_index),
        .m_map_last  (m_map_last)
    );

endmodule
